[hdl/psa_pkg.sv]
// Shared types, request and status codes for the page span allocator.
package psa_pkg;

    localparam int PAGE_NUM_W  = 10;
    localparam int PAGE_CNT_W  = 10;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int SPAN_PAGE_W = 8;
    localparam int REGION_W    = 4;
    localparam logic [REGION_W-1:0] REGION_RESET = 4'd8;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd3;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_POP_H,
        S_SPLIT,
        S_SPLIT_M1,
        S_SPLIT_M2,
        S_FILL,
        S_REL_CHK,
        S_REL_CLR,
        S_LEFT_RD,
        S_LEFT,
        S_LEFT_C1,
        S_LEFT_C2,
        S_RIGHT_RD,
        S_RIGHT,
        S_RIGHT_C1,
        S_RIGHT_C2,
        S_REL_PUSH,
        S_REL_M1,
        S_REL_M2,
        S_LOOK,
        S_ERASE_RD,
        S_ERASE,
        S_PUSH_RD,
        S_PUSH1,
        S_PUSH2
    } t_state;

endpackage

[hdl/psa_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
module psa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic [AW-1:0]    i_ra,
    output logic [WIDTH-1:0] o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

[hdl/page_span_allocator.sv]
// Page span allocator: top level with sequencer, free lists and page map.
// Allocate searches the free lists upward to MAX_SPAN_PAGES, splits off any remainder and
//   marks each page of the span; release clears each page, merges free neighbours and
//   pushes the merged span. One request at a time; busy is high meanwhile.
// The result strobe is high for one cycle and the receiver cannot stall it.
// Reset (synchronous, active low) starts a clearing pass over the page map; busy stays
//   high until it ends. Config writes are taken at any time.
module page_span_allocator #(
    parameter int TOTAL_PAGES    = 1024,
    parameter int MAX_SPAN_PAGES = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [psa_pkg::REQ_W-1:0]           i_req_type,
    input  logic [psa_pkg::PAGE_NUM_W-1:0]      i_page_number,
    input  logic [psa_pkg::PAGE_CNT_W-1:0]      i_page_count,
    input  logic                                i_cfg_we,
    input  logic [psa_pkg::REGION_W-1:0]        i_cfg_wdata,
    output logic                                o_valid,
    output logic [psa_pkg::STATUS_W-1:0]        o_status,
    output logic [psa_pkg::PAGE_NUM_W-1:0]      o_span_start,
    output logic [psa_pkg::SPAN_PAGE_W-1:0]     o_span_pages,
    output logic                                o_span_in_use
);

    // page index, span length, chunk count, map word and link half widths
    localparam int PW     = $clog2(TOTAL_PAGES);
    localparam int SW     = $clog2(MAX_SPAN_PAGES + 1);
    localparam int NCHUNK = TOTAL_PAGES / MAX_SPAN_PAGES;
    localparam int CW     = $clog2(NCHUNK + 1);
    localparam int MW     = 2 + PW + SW;
    localparam int LW     = 1 + PW;

    localparam logic [SW-1:0] MAX_SZ    = SW'(MAX_SPAN_PAGES);
    localparam logic [PW-1:0] LAST_PAGE = PW'(TOTAL_PAGES - 1);

    // sequencer
    psa_pkg::t_state r_state, n_state, r_ret, n_ret;

    // request and working registers
    logic [PW-1:0] r_pn, n_pn;      // requested page
    logic [SW-1:0] r_k, n_k;        // requested length
    logic [SW-1:0] r_i, n_i;        // list being searched
    logic [SW-1:0] r_j, n_j;        // page counter for map sweeps
    logic [PW-1:0] r_s, n_s;        // span start
    logic [SW-1:0] r_n, n_n;        // span length while merging
    logic [SW-1:0] r_sz, n_sz;      // list operand: size
    logic [PW-1:0] r_pg, n_pg;      // list operand: page
    logic [PW-1:0] r_es, n_es;      // neighbour start
    logic [SW-1:0] r_ep, n_ep;      // neighbour length
    logic          r_had, n_had;    // list had a head at push
    logic [PW-1:0] r_old, n_old;    // that old head
    logic [PW-1:0] r_idx, n_idx;    // clearing pass
    logic [CW-1:0] r_chunk, n_chunk;
    logic [psa_pkg::REGION_W-1:0] r_region;
    logic [MAX_SPAN_PAGES:0] r_ne;  // non-empty flag per list, doubles as head valid

    // result registers
    logic r_o_valid, n_o_valid, r_o_used, n_o_used;
    logic [psa_pkg::STATUS_W-1:0]    r_o_status, n_o_status;
    logic [psa_pkg::PAGE_NUM_W-1:0]  r_o_start, n_o_start;
    logic [psa_pkg::SPAN_PAGE_W-1:0] r_o_pages, n_o_pages;

    // memory ports
    logic          pm_we;
    logic [PW-1:0] pm_wa, pm_ra;
    logic [MW-1:0] pm_wd, pm_q;
    logic          lp_we, ln_we;
    logic [PW-1:0] lp_wa, ln_wa;
    logic [LW-1:0] lp_wd, ln_wd, lp_q, ln_q;
    logic          hd_we;
    logic [SW-1:0] hd_wa, hd_ra;
    logic [PW-1:0] hd_wd, hd_q;
    logic          ne_we, ne_val;
    logic [SW-1:0] ne_idx;

    // page map: {valid, in use, start, length}
    psa_ram #(.DEPTH(TOTAL_PAGES), .WIDTH(MW)) u_page_map (
        .i_clk(i_clk), .i_we(pm_we), .i_wa(pm_wa), .i_wd(pm_wd),
        .i_ra(pm_ra), .o_rd(pm_q)
    );

    // list links split in halves so that one erase writes both in the same cycle
    psa_ram #(.DEPTH(TOTAL_PAGES), .WIDTH(LW)) u_link_prev (
        .i_clk(i_clk), .i_we(lp_we), .i_wa(lp_wa), .i_wd(lp_wd),
        .i_ra(r_pg), .o_rd(lp_q)
    );

    psa_ram #(.DEPTH(TOTAL_PAGES), .WIDTH(LW)) u_link_next (
        .i_clk(i_clk), .i_we(ln_we), .i_wa(ln_wa), .i_wd(ln_wd),
        .i_ra(r_pg), .o_rd(ln_q)
    );

    // list heads; validity lives in r_ne
    psa_ram #(.DEPTH(MAX_SPAN_PAGES + 1), .WIDTH(PW)) u_heads (
        .i_clk(i_clk), .i_we(hd_we), .i_wa(hd_wa), .i_wd(hd_wd),
        .i_ra(hd_ra), .o_rd(hd_q)
    );

    // decoded map word from the last read
    logic          q_valid, q_used;
    logic [PW-1:0] q_start;
    logic [SW-1:0] q_pages;
    assign q_valid = pm_q[MW-1];
    assign q_used  = pm_q[MW-2];
    assign q_start = pm_q[SW +: PW];
    assign q_pages = pm_q[SW-1:0];

    // neighbour tests
    logic [PW-1:0] nx;
    logic right_in, left_ok, right_ok, rel_ok, fresh_ok;
    assign nx       = PW'(32'(r_s) + 32'(r_n));
    assign right_in = (32'(r_s) + 32'(r_n)) < TOTAL_PAGES;
    assign left_ok  = q_valid && !q_used && (q_pages != '0) &&
                      (32'(q_start) + 32'(q_pages) == 32'(r_s)) &&
                      (32'(q_pages) + 32'(r_n) <= MAX_SPAN_PAGES);
    assign right_ok = q_valid && !q_used && (q_pages != '0) && (q_start == nx) &&
                      (32'(nx) + 32'(q_pages) <= TOTAL_PAGES) &&
                      (32'(q_pages) + 32'(r_n) <= MAX_SPAN_PAGES);
    assign rel_ok   = q_valid && q_used && (q_start == r_pn) && (q_pages == r_k);
    assign fresh_ok = (32'(r_chunk) < 32'(r_region)) && (32'(r_chunk) < NCHUNK);

    assign hd_ra = (r_state == psa_pkg::S_SEARCH) ? r_i : r_sz;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_pn    = r_pn;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_s     = r_s;
        n_n     = r_n;
        n_sz    = r_sz;
        n_pg    = r_pg;
        n_es    = r_es;
        n_ep    = r_ep;
        n_had   = r_had;
        n_old   = r_old;
        n_idx   = r_idx;
        n_chunk = r_chunk;

        n_o_valid  = 1'b0;
        n_o_status = psa_pkg::ST_OK;
        n_o_start  = '0;
        n_o_pages  = '0;
        n_o_used   = 1'b0;

        pm_we = 1'b0;
        pm_wa = r_s;
        pm_wd = '0;
        pm_ra = r_pn;
        lp_we = 1'b0;
        lp_wa = r_pg;
        lp_wd = '0;
        ln_we = 1'b0;
        ln_wa = r_pg;
        ln_wd = '0;
        hd_we = 1'b0;
        hd_wa = r_sz;
        hd_wd = r_pg;
        ne_we  = 1'b0;
        ne_idx = r_sz;
        ne_val = 1'b0;

        unique case (r_state)
            psa_pkg::S_CLEAR: begin
                pm_we = 1'b1;
                pm_wa = r_idx;
                if (r_idx == LAST_PAGE) begin
                    n_state = psa_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            psa_pkg::S_IDLE: begin
                pm_ra = PW'(i_page_number);
                if (start) begin
                    n_pn  = PW'(i_page_number);
                    n_k   = SW'(i_page_count);
                    unique case (i_req_type)
                        psa_pkg::REQ_ALLOC: begin
                            if (32'(i_page_count) > MAX_SPAN_PAGES) begin
                                n_o_valid  = 1'b1;
                                n_o_status = psa_pkg::ST_OVERSIZE;
                            end else if (i_page_count == '0) begin
                                n_o_valid = 1'b1;
                            end else begin
                                n_i     = SW'(i_page_count);
                                n_state = psa_pkg::S_SEARCH;
                            end
                        end
                        psa_pkg::REQ_RELEASE: begin
                            if (32'(i_page_count) > MAX_SPAN_PAGES) begin
                                n_o_valid  = 1'b1;
                                n_o_status = psa_pkg::ST_OVERSIZE;
                            end else if (i_page_count == '0 ||
                                         32'(i_page_number) >= TOTAL_PAGES ||
                                         32'(i_page_number) + 32'(i_page_count)
                                             > TOTAL_PAGES) begin
                                n_o_valid  = 1'b1;
                                n_o_status = psa_pkg::ST_UNMAPPED;
                            end else begin
                                n_state = psa_pkg::S_REL_CHK;
                            end
                        end
                        psa_pkg::REQ_LOOKUP: begin
                            if (32'(i_page_number) >= TOTAL_PAGES) begin
                                n_o_valid  = 1'b1;
                                n_o_status = psa_pkg::ST_UNMAPPED;
                            end else begin
                                n_state = psa_pkg::S_LOOK;
                            end
                        end
                        default: begin
                            n_o_valid = 1'b1;
                        end
                    endcase
                end
            end

            // ---- allocate ----
            psa_pkg::S_SEARCH: begin
                if (r_ne[r_i]) begin
                    n_sz    = r_i;
                    n_state = psa_pkg::S_POP_H;
                end else if (r_i == MAX_SZ) begin
                    if (fresh_ok) begin
                        // fresh chunk goes straight to the split, no list traffic
                        n_s     = PW'(32'(r_chunk) * MAX_SPAN_PAGES);
                        n_chunk = r_chunk + 1'b1;
                        n_state = psa_pkg::S_SPLIT;
                    end else begin
                        n_o_valid  = 1'b1;
                        n_o_status = psa_pkg::ST_NOMEM;
                        n_state    = psa_pkg::S_IDLE;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            psa_pkg::S_POP_H: begin
                n_pg    = hd_q;
                n_s     = hd_q;
                n_ret   = psa_pkg::S_SPLIT;
                n_state = psa_pkg::S_ERASE_RD;
            end

            psa_pkg::S_SPLIT: begin
                n_j = '0;
                if (r_i > r_k) begin
                    n_sz    = r_i - r_k;
                    n_pg    = r_s + PW'(r_k);
                    n_ret   = psa_pkg::S_SPLIT_M1;
                    n_state = psa_pkg::S_PUSH_RD;
                end else begin
                    n_state = psa_pkg::S_FILL;
                end
            end

            psa_pkg::S_SPLIT_M1: begin
                pm_we   = 1'b1;
                pm_wa   = r_pg;
                pm_wd   = {1'b1, 1'b0, r_pg, r_sz};
                n_state = psa_pkg::S_SPLIT_M2;
            end

            psa_pkg::S_SPLIT_M2: begin
                pm_we   = 1'b1;
                pm_wa   = r_pg + PW'(r_sz) - 1'b1;
                pm_wd   = {1'b1, 1'b0, r_pg, r_sz};
                n_state = psa_pkg::S_FILL;
            end

            psa_pkg::S_FILL: begin
                pm_we = 1'b1;
                pm_wa = r_s + PW'(r_j);
                pm_wd = {1'b1, 1'b1, r_s, r_k};
                if (r_j == r_k - 1'b1) begin
                    n_o_valid = 1'b1;
                    n_o_start = psa_pkg::PAGE_NUM_W'(r_s);
                    n_o_pages = psa_pkg::SPAN_PAGE_W'(r_k);
                    n_state   = psa_pkg::S_IDLE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end

            // ---- release ----
            psa_pkg::S_REL_CHK: begin
                n_j = '0;
                if (rel_ok) begin
                    n_state = psa_pkg::S_REL_CLR;
                end else begin
                    n_o_valid  = 1'b1;
                    n_o_status = psa_pkg::ST_UNMAPPED;
                    n_state    = psa_pkg::S_IDLE;
                end
            end

            psa_pkg::S_REL_CLR: begin
                pm_we = 1'b1;
                pm_wa = r_pn + PW'(r_j);
                if (r_j == r_k - 1'b1) begin
                    n_s     = r_pn;
                    n_n     = r_k;
                    n_state = psa_pkg::S_LEFT_RD;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end

            psa_pkg::S_LEFT_RD: begin
                pm_ra = r_s - 1'b1;
                n_state = (r_s == '0) ? psa_pkg::S_RIGHT_RD : psa_pkg::S_LEFT;
            end

            psa_pkg::S_LEFT: begin
                if (left_ok) begin
                    n_sz    = q_pages;
                    n_pg    = q_start;
                    n_es    = q_start;
                    n_ep    = q_pages;
                    n_ret   = psa_pkg::S_LEFT_C1;
                    n_state = psa_pkg::S_ERASE_RD;
                end else begin
                    n_state = psa_pkg::S_RIGHT_RD;
                end
            end

            psa_pkg::S_LEFT_C1: begin
                pm_we   = 1'b1;
                pm_wa   = r_es;
                n_state = psa_pkg::S_LEFT_C2;
            end

            psa_pkg::S_LEFT_C2: begin
                pm_we   = 1'b1;
                pm_wa   = r_s - 1'b1;
                n_s     = r_es;
                n_n     = r_n + r_ep;
                n_state = psa_pkg::S_LEFT_RD;
            end

            psa_pkg::S_RIGHT_RD: begin
                pm_ra = nx;
                n_state = right_in ? psa_pkg::S_RIGHT : psa_pkg::S_REL_PUSH;
            end

            psa_pkg::S_RIGHT: begin
                if (right_ok) begin
                    n_sz    = q_pages;
                    n_pg    = nx;
                    n_ep    = q_pages;
                    n_ret   = psa_pkg::S_RIGHT_C1;
                    n_state = psa_pkg::S_ERASE_RD;
                end else begin
                    n_state = psa_pkg::S_REL_PUSH;
                end
            end

            psa_pkg::S_RIGHT_C1: begin
                pm_we   = 1'b1;
                pm_wa   = nx;
                n_state = psa_pkg::S_RIGHT_C2;
            end

            psa_pkg::S_RIGHT_C2: begin
                pm_we   = 1'b1;
                pm_wa   = nx + PW'(r_ep) - 1'b1;
                n_n     = r_n + r_ep;
                n_state = psa_pkg::S_RIGHT_RD;
            end

            psa_pkg::S_REL_PUSH: begin
                n_sz    = r_n;
                n_pg    = r_s;
                n_ret   = psa_pkg::S_REL_M1;
                n_state = psa_pkg::S_PUSH_RD;
            end

            psa_pkg::S_REL_M1: begin
                pm_we   = 1'b1;
                pm_wa   = r_s;
                pm_wd   = {1'b1, 1'b0, r_s, r_n};
                n_state = psa_pkg::S_REL_M2;
            end

            psa_pkg::S_REL_M2: begin
                pm_we     = 1'b1;
                pm_wa     = r_s + PW'(r_n) - 1'b1;
                pm_wd     = {1'b1, 1'b0, r_s, r_n};
                n_o_valid = 1'b1;
                n_state   = psa_pkg::S_IDLE;
            end

            // ---- lookup ----
            psa_pkg::S_LOOK: begin
                n_o_valid = 1'b1;
                if (q_valid) begin
                    n_o_start = psa_pkg::PAGE_NUM_W'(q_start);
                    n_o_pages = psa_pkg::SPAN_PAGE_W'(q_pages);
                    n_o_used  = q_used;
                end else begin
                    n_o_status = psa_pkg::ST_UNMAPPED;
                end
                n_state = psa_pkg::S_IDLE;
            end

            // ---- list unlink of r_pg from list r_sz ----
            psa_pkg::S_ERASE_RD: begin
                n_state = psa_pkg::S_ERASE;
            end

            psa_pkg::S_ERASE: begin
                if (lp_q[PW]) begin
                    ln_we = 1'b1;
                    ln_wa = lp_q[PW-1:0];
                    ln_wd = ln_q;
                end else begin
                    hd_we  = 1'b1;
                    hd_wd  = ln_q[PW-1:0];
                    ne_we  = 1'b1;
                    ne_val = ln_q[PW];
                end
                if (ln_q[PW]) begin
                    lp_we = 1'b1;
                    lp_wa = ln_q[PW-1:0];
                    lp_wd = lp_q;
                end
                n_state = r_ret;
            end

            // ---- list push of r_pg on list r_sz ----
            psa_pkg::S_PUSH_RD: begin
                n_state = psa_pkg::S_PUSH1;
            end

            psa_pkg::S_PUSH1: begin
                lp_we   = 1'b1;
                ln_we   = 1'b1;
                ln_wd   = {r_ne[r_sz], hd_q};
                hd_we   = 1'b1;
                ne_we   = 1'b1;
                ne_val  = 1'b1;
                n_had   = r_ne[r_sz];
                n_old   = hd_q;
                n_state = psa_pkg::S_PUSH2;
            end

            psa_pkg::S_PUSH2: begin
                if (r_had) begin
                    lp_we = 1'b1;
                    lp_wa = r_old;
                    lp_wd = {1'b1, r_pg};
                end
                n_state = r_ret;
            end

            default: begin
                n_state = psa_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psa_pkg::S_CLEAR;
            r_idx     <= '0;
            r_chunk   <= '0;
            r_region  <= psa_pkg::REGION_RESET;
            r_ne      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_chunk   <= n_chunk;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_region <= i_cfg_wdata;
            end
            if (ne_we) begin
                r_ne[ne_idx] <= ne_val;
            end
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_ret      <= n_ret;
        r_pn       <= n_pn;
        r_k        <= n_k;
        r_i        <= n_i;
        r_j        <= n_j;
        r_s        <= n_s;
        r_n        <= n_n;
        r_sz       <= n_sz;
        r_pg       <= n_pg;
        r_es       <= n_es;
        r_ep       <= n_ep;
        r_had      <= n_had;
        r_old      <= n_old;
        r_o_status <= n_o_status;
        r_o_start  <= n_o_start;
        r_o_pages  <= n_o_pages;
        r_o_used   <= n_o_used;
    end

    assign busy          = (r_state != psa_pkg::S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_span_start  = r_o_start;
    assign o_span_pages  = r_o_pages;
    assign o_span_in_use = r_o_used;

endmodule

[hdl/psa_chk.sv]
// Port-level checks for the page span allocator, bound to the top level.
module psa_chk #(
    parameter int MAX_SPAN_PAGES = 128
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [psa_pkg::REQ_W-1:0]           i_req_type,
    input logic [psa_pkg::PAGE_NUM_W-1:0]      i_page_number,
    input logic [psa_pkg::PAGE_CNT_W-1:0]      i_page_count,
    input logic                                i_cfg_we,
    input logic [psa_pkg::REGION_W-1:0]        i_cfg_wdata,
    input logic                                o_valid,
    input logic [psa_pkg::STATUS_W-1:0]        o_status,
    input logic [psa_pkg::PAGE_NUM_W-1:0]      o_span_start,
    input logic [psa_pkg::SPAN_PAGE_W-1:0]     o_span_pages,
    input logic                                o_span_in_use
);

    // map clearing pass follows every reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != psa_pkg::ST_OK |->
            o_span_start == '0 && o_span_pages == '0 && !o_span_in_use)
        else $error("error result carries span data");

    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_span_pages) <= MAX_SPAN_PAGES)
        else $error("span longer than limit");

    a_zero_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == psa_pkg::REQ_ALLOC && i_page_count == '0 |=>
            o_valid && o_status == psa_pkg::ST_OK && o_span_pages == '0)
        else $error("zero-page allocate not answered at once");

endmodule

bind page_span_allocator psa_chk #(.MAX_SPAN_PAGES(MAX_SPAN_PAGES)) u_psa_chk (.*);

[dv/page_span_allocator_tb.sv]
// Self-checking testbench for the page span allocator: predictor, driver and monitor.
`timescale 1ns / 1ps

module page_span_allocator_tb;

    localparam int NPAGES  = 1024;
    localparam int MAXSPAN = 128;

    // request code outside the defined set
    localparam logic [psa_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef enum logic {K_REQ, K_CFG} t_kind;

    // one pending transfer; from_live asks the driver to aim at a span that is held now
    typedef struct {
        t_kind                           kind;
        logic [psa_pkg::REQ_W-1:0]       req;
        logic [psa_pkg::PAGE_NUM_W-1:0]  pn;
        logic [psa_pkg::PAGE_CNT_W-1:0]  cnt;
        logic [psa_pkg::REGION_W-1:0]    region;
        bit                              from_live;
    } t_pending;

    typedef struct {
        logic [psa_pkg::STATUS_W-1:0]    status;
        logic [psa_pkg::PAGE_NUM_W-1:0]  start;
        logic [psa_pkg::SPAN_PAGE_W-1:0] pages;
        logic                            in_use;
    } t_span_result;

    typedef struct {
        int first;
        int len;
    } t_held_span;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [psa_pkg::REQ_W-1:0]        i_req_type = psa_pkg::REQ_LOOKUP;
    logic [psa_pkg::PAGE_NUM_W-1:0]   i_page_number = '0;
    logic [psa_pkg::PAGE_CNT_W-1:0]   i_page_count = '0;
    logic                             i_cfg_we = 1'b0;
    logic [psa_pkg::REGION_W-1:0]     i_cfg_wdata = psa_pkg::REGION_RESET;
    logic                             o_valid;
    logic [psa_pkg::STATUS_W-1:0]     o_status;
    logic [psa_pkg::PAGE_NUM_W-1:0]   o_span_start;
    logic [psa_pkg::SPAN_PAGE_W-1:0]  o_span_pages;
    logic                             o_span_in_use;

    page_span_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_page_number (i_page_number),
        .i_page_count  (i_page_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_span_start  (o_span_start),
        .o_span_pages  (o_span_pages),
        .o_span_in_use (o_span_in_use)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow allocator state
    // ------------------------------------------------------------------
    bit map_vld   [NPAGES];
    bit map_used  [NPAGES];
    int map_first [NPAGES];
    int map_len   [NPAGES];
    bit lnk_hp    [NPAGES];
    bit lnk_hn    [NPAGES];
    int lnk_p     [NPAGES];
    int lnk_n     [NPAGES];
    bit head_vld  [MAXSPAN+1];
    int head_pg   [MAXSPAN+1];
    bit nonempty  [MAXSPAN+1];
    int chunks_carved = 0;
    int region_lim    = psa_pkg::REGION_RESET;

    t_pending     pend_q[$];
    t_span_result expected_q[$];
    t_held_span   held_spans[$];
    bit           fill_done = 1'b0;
    int           errors    = 0;

    function automatic void map_set(int pg, bit used, int first, int len);
        if (pg >= NPAGES) return;
        map_vld[pg] = 1'b1; map_used[pg] = used; map_first[pg] = first; map_len[pg] = len;
    endfunction

    function automatic void map_wipe(int pg);
        if (pg >= NPAGES) return;
        map_vld[pg] = 1'b0; map_used[pg] = 1'b0; map_first[pg] = 0; map_len[pg] = 0;
    endfunction

    // LIFO push onto the free list for span length sz
    function automatic void fl_push(int sz, int pg);
        if (sz > MAXSPAN || pg >= NPAGES) return;
        lnk_hp[pg] = 1'b0;
        lnk_p[pg]  = 0;
        lnk_hn[pg] = head_vld[sz];
        lnk_n[pg]  = head_pg[sz];
        if (head_vld[sz] && head_pg[sz] < NPAGES) begin
            lnk_hp[head_pg[sz]] = 1'b1;
            lnk_p[head_pg[sz]]  = pg;
        end
        head_vld[sz] = 1'b1;
        head_pg[sz]  = pg;
        nonempty[sz] = 1'b1;
    endfunction

    function automatic void fl_erase(int sz, int pg);
        bit hp, hn;
        int p, n;
        if (sz > MAXSPAN || pg >= NPAGES) return;
        hp = lnk_hp[pg]; hn = lnk_hn[pg]; p = lnk_p[pg]; n = lnk_n[pg];
        if (hp && p < NPAGES) begin
            lnk_hn[p] = hn;
            lnk_n[p]  = n;
        end else begin
            head_vld[sz] = hn;
            head_pg[sz]  = n;
        end
        if (hn && n < NPAGES) begin
            lnk_hp[n] = hp;
            lnk_p[n]  = p;
        end
        nonempty[sz] = head_vld[sz];
    endfunction

    // exact fit first, else split the smallest longer free span from its front
    function automatic bit carve_from_lists(int k, output int first);
        int s, rs, rn;
        first = 0;
        for (int i = k; i <= MAXSPAN; i++) begin
            if (!nonempty[i]) continue;
            s = head_pg[i];
            fl_erase(i, s);
            if (i > k) begin
                rs = s + k;
                rn = i - k;
                fl_push(rn, rs);
                map_set(rs, 1'b0, rs, rn);
                map_set(rs + rn - 1, 1'b0, rs, rn);
            end
            for (int j = 0; j < k; j++) map_set(s + j, 1'b1, s, k);
            first = s;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_span_result span_predict(t_pending it);
        t_span_result r;
        int  pn, cnt, s, n, lim, nx, ef, el;
        bit  got;
        r   = '{psa_pkg::ST_OK, '0, '0, 1'b0};
        pn  = it.pn;
        cnt = it.cnt;
        case (it.req)
            psa_pkg::REQ_ALLOC: begin
                if (cnt > MAXSPAN) begin
                    r.status = psa_pkg::ST_OVERSIZE;
                end else if (cnt > 0) begin
                    got = carve_from_lists(cnt, s);
                    if (!got) begin
                        lim = (region_lim < NPAGES / MAXSPAN) ? region_lim : NPAGES / MAXSPAN;
                        if (chunks_carved < lim) begin
                            fl_push(MAXSPAN, chunks_carved * MAXSPAN);
                            chunks_carved++;
                            got = carve_from_lists(cnt, s);
                        end
                    end
                    if (got) begin
                        r.start = psa_pkg::PAGE_NUM_W'(s);
                        r.pages = psa_pkg::SPAN_PAGE_W'(cnt);
                        held_spans.push_back('{s, cnt});
                    end else begin
                        r.status = psa_pkg::ST_NOMEM;
                    end
                end
            end
            psa_pkg::REQ_RELEASE: begin
                if (cnt > MAXSPAN) begin
                    r.status = psa_pkg::ST_OVERSIZE;
                end else if (cnt == 0 || pn + cnt > NPAGES || !map_vld[pn] || !map_used[pn]
                             || map_first[pn] != pn || map_len[pn] != cnt) begin
                    r.status = psa_pkg::ST_UNMAPPED;
                end else begin
                    s = pn;
                    n = cnt;
                    for (int j = 0; j < cnt; j++) map_wipe(pn + j);
                    // coalesce leftwards while the merged span still fits
                    while (s > 0) begin
                        ef = map_first[s-1];
                        el = map_len[s-1];
                        if (!map_vld[s-1] || map_used[s-1] || el == 0 || ef + el != s
                            || el + n > MAXSPAN) break;
                        fl_erase(el, ef);
                        map_wipe(ef);
                        map_wipe(s - 1);
                        s = ef;
                        n += el;
                    end
                    while (s + n < NPAGES) begin
                        nx = s + n;
                        el = map_len[nx];
                        if (!map_vld[nx] || map_used[nx] || el == 0 || map_first[nx] != nx
                            || nx + el > NPAGES || el + n > MAXSPAN) break;
                        fl_erase(el, nx);
                        map_wipe(nx);
                        map_wipe(nx + el - 1);
                        n += el;
                    end
                    fl_push(n, s);
                    map_set(s, 1'b0, s, n);
                    map_set(s + n - 1, 1'b0, s, n);
                end
            end
            psa_pkg::REQ_LOOKUP: begin
                if (map_vld[pn]) begin
                    r.start  = psa_pkg::PAGE_NUM_W'(map_first[pn]);
                    r.pages  = psa_pkg::SPAN_PAGE_W'(map_len[pn]);
                    r.in_use = map_used[pn];
                end else begin
                    r.status = psa_pkg::ST_UNMAPPED;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one transfer at a time, random gap after each
    // ------------------------------------------------------------------
    t_pending cur_item;
    int       gap_left   = 0;
    int       burst_left = 0;

    always @(posedge i_clk) begin : drv
        logic     start_nx, we_nx;
        t_pending it;
        int       k;
        start_nx = start;
        we_nx    = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                // transfer taken at this edge
                expected_q.push_back(span_predict(cur_item));
                start_nx = 1'b0;
                if (burst_left > 0) begin
                    burst_left--;
                    gap_left = 0;
                end else begin
                    gap_left = $urandom_range(0, 9);
                    if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 60);
                end
            end else if (!start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() > 0) begin
                    it = pend_q[0];
                    if (it.kind == K_CFG) begin
                        // register written only once the block has drained
                        if (!busy && expected_q.size() == 0) begin
                            we_nx       = 1'b1;
                            i_cfg_wdata <= it.region;
                            region_lim  = it.region;
                            void'(pend_q.pop_front());
                        end
                    end else begin
                        void'(pend_q.pop_front());
                        if (it.from_live && held_spans.size() > 0) begin
                            k = $urandom_range(0, held_spans.size() - 1);
                            if (it.req == psa_pkg::REQ_RELEASE) begin
                                it.pn  = psa_pkg::PAGE_NUM_W'(held_spans[k].first);
                                it.cnt = psa_pkg::PAGE_CNT_W'(held_spans[k].len);
                                held_spans.delete(k);
                            end else begin
                                it.pn = psa_pkg::PAGE_NUM_W'(held_spans[k].first
                                        + $urandom_range(0, held_spans[k].len - 1));
                            end
                        end
                        cur_item      = it;
                        i_req_type    <= it.req;
                        i_page_number <= it.pn;
                        i_page_count  <= it.cnt;
                        start_nx      = 1'b1;
                    end
                end
            end
        end
        start    <= start_nx;
        i_cfg_we <= we_nx;
    end

    // ------------------------------------------------------------------
    // Monitor: results cannot be stalled, so sample every strobe
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_span_result exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d start=%0d pages=%0d in_use=%0d",
                         $time, o_status, o_span_start, o_span_pages, o_span_in_use);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, o_status);
                    errors++;
                end
                if (o_span_start !== exp_r.start) begin
                    $display("%0t: span_start exp %0d got %0d", $time, exp_r.start,
                             o_span_start);
                    errors++;
                end
                if (o_span_pages !== exp_r.pages) begin
                    $display("%0t: span_pages exp %0d got %0d", $time, exp_r.pages,
                             o_span_pages);
                    errors++;
                end
                if (o_span_in_use !== exp_r.in_use) begin
                    $display("%0t: span_in_use exp %0d got %0d", $time, exp_r.in_use,
                             o_span_in_use);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void add_req(logic [psa_pkg::REQ_W-1:0] req, int pn, int cnt,
                                    bit live);
        pend_q.push_back('{K_REQ, req, pn[psa_pkg::PAGE_NUM_W-1:0],
                           cnt[psa_pkg::PAGE_CNT_W-1:0], '0, live});
    endfunction

    function automatic void add_cfg(int region);
        pend_q.push_back('{K_CFG, psa_pkg::REQ_LOOKUP, '0, '0,
                           region[psa_pkg::REGION_W-1:0], 1'b0});
    endfunction

    // mostly well-formed traffic: allocs paired with releases of held spans
    function automatic void add_random(int n);
        int r, sz;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                sz = $urandom_range(0, 99);
                if (sz < 70)      sz = $urandom_range(1, 16);
                else if (sz < 90) sz = $urandom_range(17, 128);
                else if (sz < 94) sz = MAXSPAN;
                else if (sz < 97) sz = $urandom_range(129, 1023);
                else              sz = 0;
                add_req(psa_pkg::REQ_ALLOC, $urandom_range(0, 1023), sz, 1'b0);
            end else if (r < 80) begin
                if ($urandom_range(0, 9) != 0)
                    add_req(psa_pkg::REQ_RELEASE, 0, 0, 1'b1);
                else
                    add_req(psa_pkg::REQ_RELEASE, $urandom_range(0, 1023),
                            $urandom_range(0, 1023), 1'b0);
            end else if (r < 97) begin
                add_req(psa_pkg::REQ_LOOKUP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 4) < 3);
            end else begin
                add_req(REQ_UNKNOWN, $urandom_range(0, 1023), $urandom_range(0, 1023), 1'b0);
            end
        end
    endfunction

    initial begin
        // directed: field extremes, every request type, error paths and merges
        add_req(psa_pkg::REQ_ALLOC,   0,    0,    1'b0);   // zero-page allocate
        add_req(psa_pkg::REQ_LOOKUP,  1023, 1023, 1'b0);   // never mapped
        add_req(psa_pkg::REQ_ALLOC,   1023, 1,    1'b0);
        add_req(psa_pkg::REQ_ALLOC,   0,    3,    1'b0);
        add_req(psa_pkg::REQ_ALLOC,   0,    128,  1'b0);   // fresh chunk, exact fit
        add_req(psa_pkg::REQ_ALLOC,   0,    129,  1'b0);   // oversize
        add_req(psa_pkg::REQ_ALLOC,   0,    1023, 1'b0);
        add_req(psa_pkg::REQ_LOOKUP,  1,    0,    1'b0);   // head page of the 3-page span
        add_req(psa_pkg::REQ_LOOKUP,  4,    0,    1'b0);   // head of the free remainder
        add_req(psa_pkg::REQ_LOOKUP,  10,   0,    1'b0);   // interior of free span: unmapped
        add_req(psa_pkg::REQ_LOOKUP,  127,  0,    1'b0);   // tail of the free remainder
        add_req(psa_pkg::REQ_RELEASE, 1,    2,    1'b0);   // wrong length
        add_req(psa_pkg::REQ_RELEASE, 1,    0,    1'b0);   // zero length
        add_req(psa_pkg::REQ_RELEASE, 0,    1023, 1'b0);   // oversize release
        add_req(psa_pkg::REQ_RELEASE, 1,    3,    1'b0);   // merges right
        add_req(psa_pkg::REQ_RELEASE, 1,    3,    1'b0);   // double release
        add_req(psa_pkg::REQ_RELEASE, 0,    1,    1'b0);   // merges right
        add_req(psa_pkg::REQ_LOOKUP,  0,    0,    1'b0);
        add_req(psa_pkg::REQ_RELEASE, 1023, 1,    1'b0);   // last page, never mapped
        add_req(REQ_UNKNOWN,          1023, 1023, 1'b0);   // unknown request
        add_req(psa_pkg::REQ_ALLOC,   0,    127,  1'b0);
        add_req(psa_pkg::REQ_LOOKUP,  512,  5,    1'b0);
        // random phases over several region limits
        add_cfg(1);
        add_random(300);
        add_cfg(15);
        add_random(550);
        add_cfg(4);
        add_random(350);
        add_cfg(8);
        add_random(330);
        fill_done = 1'b1;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : finish_blk
        wait (fill_done);
        @(posedge i_clk);
        while (pend_q.size() > 0 || start || expected_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASS page_span_allocator");
        end else begin
            $display("FAIL page_span_allocator");
        end
        $finish;
    end

    // generous ceiling: reset clearing plus worst-case allocate and release times
    initial begin : watchdog
        #80ms;
        $display("FAIL page_span_allocator");
        $finish;
    end

endmodule

[page_span_allocator.f]
hdl/psa_pkg.sv
hdl/psa_ram.sv
hdl/page_span_allocator.sv
hdl/psa_chk.sv
dv/page_span_allocator_tb.sv
